// ===== hw/rtl/bcfr_pkg.sv =====
// Package for the bit-coded field reader.
// Holds the field kind codes, shared constants and the result and state types.
// Has no dependencies.
package bcfr_pkg;

  localparam logic [3:0] FUNC_BIT       = 4'd0;
  localparam logic [3:0] FUNC_TWO_BITS  = 4'd1;
  localparam logic [3:0] FUNC_THREE_BIT = 4'd2;
  localparam logic [3:0] FUNC_BITSHORT  = 4'd3;
  localparam logic [3:0] FUNC_BITLONG   = 4'd4;
  localparam logic [3:0] FUNC_BITLLONG  = 4'd5;
  localparam logic [3:0] FUNC_BITDOUBLE = 4'd6;
  localparam logic [3:0] FUNC_RAW8      = 4'd7;
  localparam logic [3:0] FUNC_RAW16     = 4'd8;
  localparam logic [3:0] FUNC_RAW32     = 4'd9;
  localparam logic [3:0] FUNC_RAWDOUBLE = 4'd10;
  localparam logic [3:0] FUNC_MODCHAR   = 4'd11;
  localparam logic [3:0] FUNC_MODSHORT  = 4'd12;
  localparam logic [3:0] FUNC_HANDLE    = 4'd13;
  localparam logic [3:0] FUNC_ALIGN     = 4'd14;

  localparam logic [1:0] PFX_FULL  = 2'd0;
  localparam logic [1:0] PFX_BYTE  = 2'd1;
  localparam logic [1:0] PFX_ZERO  = 2'd2;
  localparam logic [1:0] PFX_OTHER = 2'd3;

  localparam logic [63:0] ONE_DOUBLE_BITS = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] SHORT_256       = 64'd256;
  localparam logic [3:0]  MAX_HANDLE_SIZE = 4'd4;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  handle_code;
    logic [3:0]  bytes_taken;
    logic        error;
  } result_t;

  typedef struct packed {
    logic [2:0] bit_offset;
    logic [7:0] held_byte;
  } rd_state_t;

endpackage

// ===== hw/rtl/bcfr_decode.sv =====
// Combinational field decoder of the bit-coded field reader.
// Aligns the stream at the current bit offset and decodes one field.
// Depends on bcfr_pkg.
module bcfr_decode
  import bcfr_pkg::*;
(
  input  logic [3:0]  func,
  input  logic [63:0] window_bytes,
  input  logic [7:0]  ninth_byte,
  input  rd_state_t   state,
  output result_t     result,
  output rd_state_t   state_next
);

  function automatic logic [7:0] get_byte(input logic [71:0] a, input int unsigned k);
    return a[71-k -: 8];
  endfunction

  function automatic logic [15:0] get_le2(input logic [71:0] a, input int unsigned k);
    return {get_byte(a, k + 8), get_byte(a, k)};
  endfunction

  function automatic logic [31:0] get_le4(input logic [71:0] a, input int unsigned k);
    return {get_le2(a, k + 16), get_le2(a, k)};
  endfunction

  function automatic logic [63:0] get_le8(input logic [71:0] a, input int unsigned k);
    return {get_le4(a, k + 32), get_le4(a, k)};
  endfunction

  logic [63:0] swapped;
  logic [79:0] stream;
  logic [79:0] shifted;
  logic [79:0] held_sel;
  logic [71:0] a;
  logic [3:0]  p0;
  logic [6:0]  nbits;
  logic [6:0]  q;
  logic [6:0]  qm1;
  logic [63:0] value;
  logic [3:0]  hcode;
  logic        err;
  logic        keep;
  logic        align;
  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] w0, w1;
  logic [28:0] acc;
  logic        sign;
  logic [63:0] mag;
  logic [2:0]  llen;
  logic [3:0]  hsize;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      swapped[63-8*i -: 8] = window_bytes[8*i +: 8];
    end
    stream  = {state.held_byte, swapped, ninth_byte};
    p0      = (state.bit_offset == 3'd0) ? 4'd8 : {1'b0, state.bit_offset};
    shifted = stream << p0;
    a       = shifted[79:8];

    b0    = get_byte(a, 0);
    b1    = get_byte(a, 8);
    b2    = get_byte(a, 16);
    b3    = get_byte(a, 24);
    w0    = get_le2(a, 0);
    w1    = get_le2(a, 16);
    llen  = a[71:69];
    hsize = b0[3:0];

    nbits = 7'd0;
    value = 64'd0;
    hcode = 4'd0;
    err   = 1'b0;
    keep  = 1'b0;
    align = 1'b0;
    acc   = 29'd0;
    sign  = 1'b0;

    case (func)
      FUNC_BIT: begin
        value = {63'd0, a[71]};
        nbits = 7'd1;
      end
      FUNC_TWO_BITS: begin
        value = {62'd0, a[71:70]};
        nbits = 7'd2;
      end
      FUNC_THREE_BIT: begin
        if (!a[71]) begin
          value = 64'd0;
          nbits = 7'd1;
        end else if (!a[70]) begin
          value = 64'd2;
          nbits = 7'd2;
        end else if (!a[69]) begin
          value = 64'd6;
          nbits = 7'd3;
        end else begin
          value = 64'd7;
          nbits = 7'd3;
        end
      end
      FUNC_BITSHORT: begin
        case (a[71:70])
          PFX_FULL: begin
            value = {48'd0, get_le2(a, 2)};
            nbits = 7'd18;
          end
          PFX_BYTE: begin
            value = {56'd0, get_byte(a, 2)};
            nbits = 7'd10;
          end
          PFX_ZERO: nbits = 7'd2;
          default: begin
            value = SHORT_256;
            nbits = 7'd2;
          end
        endcase
      end
      FUNC_BITLONG: begin
        case (a[71:70])
          PFX_FULL: begin
            value = {32'd0, get_le4(a, 2)};
            nbits = 7'd34;
          end
          PFX_BYTE: begin
            value = {56'd0, get_byte(a, 2)};
            nbits = 7'd10;
          end
          PFX_ZERO: nbits = 7'd2;
          default: err = 1'b1;
        endcase
      end
      FUNC_BITLLONG: begin
        for (int i = 0; i < 7; i++) begin
          if (3'(i) < llen) begin
            value[8*i +: 8] = get_byte(a, 3 + 8*i);
          end
        end
        nbits = 7'd3 + {1'b0, llen, 3'b000};
      end
      FUNC_BITDOUBLE: begin
        case (a[71:70])
          PFX_FULL: begin
            value = get_le8(a, 2);
            nbits = 7'd66;
          end
          PFX_BYTE: begin
            value = ONE_DOUBLE_BITS;
            nbits = 7'd2;
          end
          PFX_ZERO: nbits = 7'd2;
          default: err = 1'b1;
        endcase
      end
      FUNC_RAW8: begin
        value = {56'd0, b0};
        nbits = 7'd8;
      end
      FUNC_RAW16: begin
        value = {48'd0, w0};
        nbits = 7'd16;
      end
      FUNC_RAW32: begin
        value = {32'd0, get_le4(a, 0)};
        nbits = 7'd32;
      end
      FUNC_RAWDOUBLE: begin
        value = get_le8(a, 0);
        nbits = 7'd64;
      end
      FUNC_MODCHAR: begin
        if (!b0[7]) begin
          acc   = {23'd0, b0[5:0]};
          sign  = b0[6];
          nbits = 7'd8;
        end else if (!b1[7]) begin
          acc   = {16'd0, b1[5:0], b0[6:0]};
          sign  = b1[6];
          nbits = 7'd16;
        end else if (!b2[7]) begin
          acc   = {9'd0, b2[5:0], b1[6:0], b0[6:0]};
          sign  = b2[6];
          nbits = 7'd24;
        end else if (!b3[7]) begin
          acc   = {2'd0, b3[5:0], b2[6:0], b1[6:0], b0[6:0]};
          sign  = b3[6];
          nbits = 7'd32;
        end else begin
          err = 1'b1;
        end
      end
      FUNC_MODSHORT: begin
        if (!w0[15]) begin
          acc   = {15'd0, w0[13:0]};
          sign  = w0[14];
          nbits = 7'd16;
        end else if (!w1[15]) begin
          acc   = {w1[13:0], w0[14:0]};
          sign  = w1[14];
          nbits = 7'd32;
        end else begin
          err = 1'b1;
        end
      end
      FUNC_HANDLE: begin
        if (hsize > MAX_HANDLE_SIZE) begin
          err = 1'b1;
        end else begin
          hcode = b0[7:4];
          nbits = 7'd8 + {1'b0, hsize[2:0], 3'b000};
          case (hsize[2:0])
            3'd1:    value = {56'd0, a[63:56]};
            3'd2:    value = {48'd0, a[63:48]};
            3'd3:    value = {40'd0, a[63:40]};
            3'd4:    value = {32'd0, a[63:32]};
            default: value = 64'd0;
          endcase
        end
      end
      FUNC_ALIGN: align = 1'b1;
      default:    keep = 1'b1;
    endcase

    if (func == FUNC_MODCHAR || func == FUNC_MODSHORT) begin
      mag   = {35'd0, acc};
      value = sign ? (64'd0 - mag) : mag;
    end else begin
      mag = 64'd0;
    end

    q        = {3'd0, p0} + nbits;
    qm1      = q - 7'd1;
    held_sel = stream << {q[6:3], 3'b000};

    result = '0;
    state_next = state;
    if (err) begin
      result.error = 1'b1;
    end else if (align) begin
      state_next = '0;
    end else if (!keep) begin
      result.value       = value;
      result.handle_code = hcode;
      result.bytes_taken = qm1[6:3];
      state_next.bit_offset = q[2:0];
      state_next.held_byte  = (q[2:0] != 3'd0) ? held_sel[79:72] : 8'd0;
    end
  end

endmodule

// ===== hw/rtl/bit_coded_field_reader_core.sv =====
// Bit-coded field reader: one field of an MSB-first bitstream per item, with the
// decode between an input register and a result register.
// Depends on bcfr_pkg and bcfr_decode.

// The block takes one item per cycle while the output is not stalled, and
// returns one result for each item. Each item is held in the input register,
// and its result is loaded into the result register once the output can advance.
// Each item names the field kind and carries the next nine unread stream bytes;
// the result tells how many of them the host must step past before it sends the
// next item. The bit offset and the partly used byte are updated as each item
// leaves the decode stage, so the next item already sees them; the rate is one
// item per cycle while the output is not stalled, set by the single decode stage.
module bit_coded_field_reader_core
  import bcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // window_bytes[63:0], ninth_byte[71:64]
  input  logic [3:0]  s_tuser,  // func[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // value[63:0], handle_code[67:64], bytes_taken[71:68]
  output logic        m_tuser   // error[0]
);

  logic        in_valid;
  logic [3:0]  in_func;
  logic [63:0] in_window;
  logic [7:0]  in_ninth;
  logic        adv;
  rd_state_t   state;
  rd_state_t   state_next;
  result_t     result;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  bcfr_decode u_decode (
    .func         (in_func),
    .window_bytes (in_window),
    .ninth_byte   (in_ninth),
    .state        (state),
    .result       (result),
    .state_next   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func   <= s_tuser;
      in_window <= s_tdata[63:0];
      in_ninth  <= s_tdata[71:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      state    <= '0;
    end else if (adv) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      m_tdata <= {result.bytes_taken, result.handle_code, result.value};
      m_tuser <= result.error;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_clears_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 72'd0))
    else $error("error result carries nonzero data");

  a_taken_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[71:68] <= 4'd9))
    else $error("bytes_taken above nine");

  a_no_partial_byte: assert property (@(posedge clk) disable iff (rst)
    (state.bit_offset == 3'd0) |-> (state.held_byte == 8'd0))
    else $error("held byte kept with zero bit offset");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !rst) |=> $stable(state))
    else $error("reader state changed while the output was stalled");
`endif

endmodule
